// File: rtl/core/integer_to_ascii_converter_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the integer to ASCII converter
// Each macro expands to one labeled concurrent assertion, sampled on clk
// and disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_CONVERTER_ASSERT_SVH
`define INTEGER_TO_ASCII_CONVERTER_ASSERT_SVH

// same-cycle implication
`define ITOA_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("itoa assertion failed");

// next-cycle implication
`define ITOA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("itoa assertion failed");

`endif

// File: rtl/core/itoa_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// itoa_pkg
// Shared widths, operation codes, character codes and the load word passed
// from the converter control to the character serializer.
// ---------------------------------------------------------------------------
package itoa_pkg;

	// operand widths
	localparam int INT_WIDTH = 32;
	localparam int PTR_WIDTH = 64;

	function automatic int imax(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

	// digit counts per format (1233/4096 approximates log10(2))
	localparam int DEC_DIGITS  = ((INT_WIDTH * 1233) >> 12) + 1;
	localparam int OCT_DIGITS  = (INT_WIDTH + 2) / 3;
	localparam int HEX_DIGITS  = (INT_WIDTH + 3) / 4;
	localparam int PHEX_DIGITS = (PTR_WIDTH + 3) / 4;

	localparam int BCD_W = 4 * DEC_DIGITS;
	localparam int DIG_W = imax(imax(BCD_W, 3 * OCT_DIGITS),
		imax(4 * HEX_DIGITS, 4 * PHEX_DIGITS));
	localparam int MAX_DIGITS = imax(imax(DEC_DIGITS, OCT_DIGITS),
		imax(HEX_DIGITS, PHEX_DIGITS));
	localparam int CNT_W = $clog2(MAX_DIGITS + 1);

	// operation codes
	typedef enum logic [2:0] {
		OP_SDEC = 3'd0,
		OP_UDEC = 3'd1,
		OP_OCT  = 3'd2,
		OP_HEX  = 3'd3,
		OP_PTR  = 3'd4
	} op_t;

	// character codes
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_LA    = 8'h61;

	// one hex digit to its ASCII code
	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic lower);
		logic [7:0] base;
		begin
			base = lower ? CH_LA : CH_UA;
			if (d < 4'd10)
				digit_char = CH_ZERO + {4'd0, d};
			else
				digit_char = base + {4'd0, d} - 8'd10;
		end
	endfunction

	// load word for the serializer
	typedef struct packed {
		logic             go;
		logic [DIG_W-1:0] dig;
		logic [CNT_W-1:0] count;
		logic             oct;
		logic             lower;
		logic             pre_minus;
		logic             pre_0x;
	} load_t;

endpackage

// File: rtl/core/itoa_dabble.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// itoa_dabble
// Binary to BCD converter, shift-and-add-3, one input bit per cycle.
// ---------------------------------------------------------------------------
module itoa_dabble (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [itoa_pkg::INT_WIDTH-1:0]  bin,
	output logic                            busy,
	output logic                            done,
	output logic [itoa_pkg::BCD_W-1:0]      bcd
);

	localparam int SH_W  = itoa_pkg::BCD_W + itoa_pkg::INT_WIDTH;
	localparam int CTR_W = $clog2(itoa_pkg::INT_WIDTH + 1);

	logic [SH_W-1:0]            sh_q;
	logic [SH_W-1:0]            sh_next;
	logic [itoa_pkg::BCD_W-1:0] adj;
	logic [CTR_W-1:0]           cnt_q;
	logic                       busy_q;
	logic                       done_q;

	// add 3 to every BCD digit of 5 or more, then shift one bit in
	always_comb begin
		adj = sh_q[SH_W-1 -: itoa_pkg::BCD_W];
		for (int i = 0; i < itoa_pkg::DEC_DIGITS; i++) begin
			if (adj[4*i +: 4] >= 4'd5)
				adj[4*i +: 4] = adj[4*i +: 4] + 4'd3;
		end
		sh_next = {adj, sh_q[itoa_pkg::INT_WIDTH-1:0]} << 1;
	end

	// shift register
	always_ff @(posedge clk) begin
		if (start)
			sh_q <= {{itoa_pkg::BCD_W{1'b0}}, bin};
		else if (busy_q)
			sh_q <= sh_next;
	end

	// bit counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CTR_W'(itoa_pkg::INT_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CTR_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign bcd  = sh_q[SH_W-1 -: itoa_pkg::BCD_W];

endmodule

// File: rtl/core/itoa_serializer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// itoa_serializer
// Shifts digits out of a top-aligned register, 3 or 4 bits per cycle if not
// stalled, drops leading zeros, adds prefixes and holds one output word.
// ---------------------------------------------------------------------------
module itoa_serializer (
	input  logic            clk,
	input  logic            arst_n,
	input  itoa_pkg::load_t load,
	output logic            busy,
	output logic            text_valid,
	input  logic            text_ready,
	output logic [7:0]      character,
	output logic            last
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_PRE0,
		S_PRE1,
		S_DIG
	} ser_state_t;

	ser_state_t                   state_q;
	logic [itoa_pkg::DIG_W-1:0]   dig_q;
	logic [itoa_pkg::DIG_W-1:0]   dig_next;
	logic [itoa_pkg::CNT_W-1:0]   rem_q;
	logic                         oct_q;
	logic                         lower_q;
	logic                         pre_0x_q;
	logic                         started_q;
	logic                         valid_q;
	logic [7:0]                   char_q;
	logic                         last_q;
	logic [3:0]                   digit;
	logic                         skip;
	logic                         take;
	logic                         emit;

	// current digit and shift
	always_comb begin
		digit    = oct_q ? {1'b0, dig_q[itoa_pkg::DIG_W-1 -: 3]}
			: dig_q[itoa_pkg::DIG_W-1 -: 4];
		dig_next = oct_q ? (dig_q << 3) : (dig_q << 4);
		skip     = (state_q == S_DIG) && !started_q && (digit == 4'd0)
			&& (rem_q > itoa_pkg::CNT_W'(1));
		take     = !valid_q || text_ready;
		// a new character goes into the output register this cycle
		emit     = take && ((state_q == S_PRE0) || (state_q == S_PRE1)
			|| ((state_q == S_DIG) && !skip));
	end

	// sequencer and output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			dig_q     <= '0;
			rem_q     <= '0;
			oct_q     <= 1'b0;
			lower_q   <= 1'b0;
			pre_0x_q  <= 1'b0;
			started_q <= 1'b0;
			valid_q   <= 1'b0;
			char_q    <= '0;
			last_q    <= 1'b0;
		end else begin
			if (emit)
				valid_q <= 1'b1;
			else if (text_ready)
				valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (load.go) begin
						dig_q     <= load.dig;
						rem_q     <= load.count;
						oct_q     <= load.oct;
						lower_q   <= load.lower;
						pre_0x_q  <= load.pre_0x;
						started_q <= 1'b0;
						state_q   <= (load.pre_minus || load.pre_0x) ? S_PRE0 : S_DIG;
					end
				end
				S_PRE0: begin
					if (take) begin
						char_q  <= pre_0x_q ? itoa_pkg::CH_ZERO : itoa_pkg::CH_MINUS;
						last_q  <= 1'b0;
						state_q <= pre_0x_q ? S_PRE1 : S_DIG;
					end
				end
				S_PRE1: begin
					if (take) begin
						char_q  <= itoa_pkg::CH_X;
						last_q  <= 1'b0;
						state_q <= S_DIG;
					end
				end
				S_DIG: begin
					if (skip) begin
						dig_q <= dig_next;
						rem_q <= rem_q - 1'b1;
					end else if (take) begin
						char_q    <= itoa_pkg::digit_char(digit, lower_q);
						last_q    <= (rem_q == itoa_pkg::CNT_W'(1));
						dig_q     <= dig_next;
						rem_q     <= rem_q - 1'b1;
						started_q <= 1'b1;
						if (rem_q == itoa_pkg::CNT_W'(1))
							state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy       = (state_q != S_IDLE);
	assign text_valid = valid_q;
	assign character  = char_q;
	assign last       = last_q;

endmodule

// File: rtl/core/integer_to_ascii_converter.sv
`timescale 1ns / 1ps
// Sequence: octal, hex and pointer words load the serializer on accept;
//   decimal words first pass the bit-serial BCD conversion; each skipped
//   leading zero delays the first digit.
// Flow: each digit position, leading zeros included, and each prefix
//   character takes a serializer step, as do load and return to idle;
//   text stalls add. A new word is accepted only once the block is idle.
// Reset: arst_n clears all control state; the block comes up idle.
// ---------------------------------------------------------------------------
// integer_to_ascii_converter
// Converts one integer per word to ASCII text in signed/unsigned decimal,
// octal, uppercase hex or 0x-prefixed lowercase pointer hex.
// ---------------------------------------------------------------------------
`include "integer_to_ascii_converter_assert.svh"

module integer_to_ascii_converter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [2:0]  operation,
	input  logic [63:0] value,
	output logic        text_valid,
	input  logic        text_ready,
	output logic [7:0]  character,
	output logic        last
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_EMIT
	} ctl_state_t;

	ctl_state_t                     state_q;
	logic                           neg_q;
	logic                           accept;
	logic                           op_ok;
	logic                           op_dec;
	logic [itoa_pkg::INT_WIDTH-1:0] mag;
	logic [itoa_pkg::INT_WIDTH-1:0] absval;
	logic                           neg;
	logic                           dab_busy;
	logic                           dab_done;
	logic [itoa_pkg::BCD_W-1:0]     bcd;
	logic                           ser_busy;
	itoa_pkg::load_t                ld;

	// operand decode
	always_comb begin
		accept = item_valid && item_ready;
		op_ok  = operation inside {itoa_pkg::OP_SDEC, itoa_pkg::OP_UDEC,
			itoa_pkg::OP_OCT, itoa_pkg::OP_HEX, itoa_pkg::OP_PTR};
		op_dec = operation inside {itoa_pkg::OP_SDEC, itoa_pkg::OP_UDEC};
		mag    = value[itoa_pkg::INT_WIDTH-1:0];
		neg    = (operation == itoa_pkg::OP_SDEC) && mag[itoa_pkg::INT_WIDTH-1];
		absval = neg ? (~mag + 1'b1) : mag;
	end

	// serializer load word
	always_comb begin
		ld           = '0;
		ld.pre_minus = neg_q;
		ld.dig       = itoa_pkg::DIG_W'(bcd) << (itoa_pkg::DIG_W - itoa_pkg::BCD_W);
		ld.count     = itoa_pkg::CNT_W'(itoa_pkg::DEC_DIGITS);
		if (state_q == ST_CONV) begin
			ld.go = dab_done;
		end else begin
			ld.pre_minus = 1'b0;
			case (operation)
				itoa_pkg::OP_OCT: begin
					ld.go    = accept;
					ld.oct   = 1'b1;
					ld.dig   = itoa_pkg::DIG_W'(mag)
						<< (itoa_pkg::DIG_W - 3 * itoa_pkg::OCT_DIGITS);
					ld.count = itoa_pkg::CNT_W'(itoa_pkg::OCT_DIGITS);
				end
				itoa_pkg::OP_HEX: begin
					ld.go    = accept;
					ld.dig   = itoa_pkg::DIG_W'(mag)
						<< (itoa_pkg::DIG_W - 4 * itoa_pkg::HEX_DIGITS);
					ld.count = itoa_pkg::CNT_W'(itoa_pkg::HEX_DIGITS);
				end
				itoa_pkg::OP_PTR: begin
					ld.go     = accept;
					ld.lower  = 1'b1;
					ld.pre_0x = 1'b1;
					ld.dig    = itoa_pkg::DIG_W'(value[itoa_pkg::PTR_WIDTH-1:0])
						<< (itoa_pkg::DIG_W - 4 * itoa_pkg::PHEX_DIGITS);
					ld.count  = itoa_pkg::CNT_W'(itoa_pkg::PHEX_DIGITS);
				end
				default: ld.go = 1'b0;
			endcase
		end
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			neg_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && op_ok) begin
						neg_q   <= neg;
						state_q <= op_dec ? ST_CONV : ST_EMIT;
					end
				end
				ST_CONV: begin
					if (dab_done)
						state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!ser_busy)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign item_ready = (state_q == ST_IDLE);

	itoa_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && op_dec),
		.bin    (absval),
		.busy   (dab_busy),
		.done   (dab_done),
		.bcd    (bcd)
	);

	itoa_serializer u_serializer (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (ld),
		.busy       (ser_busy),
		.text_valid (text_valid),
		.text_ready (text_ready),
		.character  (character),
		.last       (last)
	);

	// checks
	`ITOA_ASSERT_SAME(a_dabble_in_conv, dab_busy, state_q == ST_CONV)
	`ITOA_ASSERT_SAME(a_ser_in_emit, ser_busy, state_q == ST_EMIT)
	`ITOA_ASSERT_SAME(a_no_accept_busy, accept, !ser_busy && !dab_busy)
	`ITOA_ASSERT_NEXT(a_conv_done_loads, dab_done, ser_busy && state_q == ST_EMIT)

endmodule
